FILE: hdl/khr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khr_pkg: shared types, constants and key code tables
// Types and lookup functions for the key event to HID report converter.
// ----------------------------------------------------------------------------
package khr_pkg;

    // number of key slots held in the cell row
    localparam int KEY_SLOTS = 6;
    // number of slot fields in the report
    localparam int OUT_SLOTS = 6;

    // platform codes of the eight modifier keys
    localparam logic [7:0] CODE_LCTRL  = 8'd113;
    localparam logic [7:0] CODE_RCTRL  = 8'd114;
    localparam logic [7:0] CODE_LSHIFT = 8'd59;
    localparam logic [7:0] CODE_RSHIFT = 8'd60;
    localparam logic [7:0] CODE_LALT   = 8'd57;
    localparam logic [7:0] CODE_RALT   = 8'd58;
    localparam logic [7:0] CODE_LGUI   = 8'd117;
    localparam logic [7:0] CODE_RGUI   = 8'd118;

    // input transaction
    typedef struct packed {
        logic [7:0] key_code;
        logic       key_down;
    } t_key_event;

    // output transaction
    typedef struct packed {
        logic       handled;
        logic [7:0] modifier_byte;
        logic [7:0] slot_zero;
        logic [7:0] slot_one;
        logic [7:0] slot_two;
        logic [7:0] slot_three;
        logic [7:0] slot_four;
        logic [7:0] slot_five;
    } t_hid_report;

    // decoded event held between decode and the cell row
    typedef struct packed {
        logic       handled;
        logic       key_down;
        logic [7:0] mod_mask;
        logic [7:0] hid;
    } t_decoded;

    // command broadcast to every cell
    typedef struct packed {
        logic       press;
        logic       release_key;
        logic       any_hit;
        logic [7:0] hid;
    } t_cell_cmd;

    // flags handed from one cell to the next
    typedef struct packed {
        logic hit;
        logic free;
    } t_cell_link;

    // modifier bit for a platform code, zero when not a modifier
    function automatic logic [7:0] modifier_mask(input logic [7:0] code);
        logic [7:0] m;
        unique case (code)
            CODE_LCTRL:  m = 8'h01;
            CODE_LSHIFT: m = 8'h02;
            CODE_LALT:   m = 8'h04;
            CODE_LGUI:   m = 8'h08;
            CODE_RCTRL:  m = 8'h10;
            CODE_RSHIFT: m = 8'h20;
            CODE_RALT:   m = 8'h40;
            CODE_RGUI:   m = 8'h80;
            default:     m = 8'h00;
        endcase
        return m;
    endfunction

    // platform code to HID usage, zero means unmapped
    function automatic logic [7:0] hid_lookup(input logic [7:0] code);
        logic [7:0] h;
        unique case (code)
            8'd7:    h = 8'h27;
            8'd8:    h = 8'h1E;
            8'd9:    h = 8'h1F;
            8'd10:   h = 8'h20;
            8'd11:   h = 8'h21;
            8'd12:   h = 8'h22;
            8'd13:   h = 8'h23;
            8'd14:   h = 8'h24;
            8'd15:   h = 8'h25;
            8'd16:   h = 8'h26;
            8'd19:   h = 8'h52;
            8'd20:   h = 8'h51;
            8'd21:   h = 8'h50;
            8'd22:   h = 8'h4F;
            8'd29:   h = 8'h04;
            8'd30:   h = 8'h05;
            8'd31:   h = 8'h06;
            8'd32:   h = 8'h07;
            8'd33:   h = 8'h08;
            8'd34:   h = 8'h09;
            8'd35:   h = 8'h0A;
            8'd36:   h = 8'h0B;
            8'd37:   h = 8'h0C;
            8'd38:   h = 8'h0D;
            8'd39:   h = 8'h0E;
            8'd40:   h = 8'h0F;
            8'd41:   h = 8'h10;
            8'd42:   h = 8'h11;
            8'd43:   h = 8'h12;
            8'd44:   h = 8'h13;
            8'd45:   h = 8'h14;
            8'd46:   h = 8'h15;
            8'd47:   h = 8'h16;
            8'd48:   h = 8'h17;
            8'd49:   h = 8'h18;
            8'd50:   h = 8'h19;
            8'd51:   h = 8'h1A;
            8'd52:   h = 8'h1B;
            8'd53:   h = 8'h1C;
            8'd54:   h = 8'h1D;
            8'd61:   h = 8'h2B;
            8'd62:   h = 8'h2C;
            8'd66:   h = 8'h28;
            8'd67:   h = 8'h2A;
            8'd68:   h = 8'h35;
            8'd69:   h = 8'h2D;
            8'd70:   h = 8'h2E;
            8'd71:   h = 8'h2F;
            8'd72:   h = 8'h30;
            8'd73:   h = 8'h31;
            8'd74:   h = 8'h33;
            8'd75:   h = 8'h34;
            8'd111:  h = 8'h29;
            8'd112:  h = 8'h4C;
            default: h = 8'h00;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/khr_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khr_decode: key event decode stage
// Looks up the modifier bit and HID usage of an event and registers them.
// ----------------------------------------------------------------------------
module khr_decode import khr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_valid,
    input  wire t_key_event i_event,
    output logic            o_valid,
    output t_decoded        o_dec
);

    logic       r_valid;
    t_decoded   r_dec;
    t_decoded   n_dec;
    logic [7:0] mod_mask;
    logic [7:0] hid;

    // modifier decode wins over the table
    always_comb begin
        mod_mask         = modifier_mask(i_event.key_code);
        hid              = (mod_mask != 8'h00) ? 8'h00 : hid_lookup(i_event.key_code);
        n_dec.mod_mask   = mod_mask;
        n_dec.hid        = hid;
        n_dec.key_down   = i_event.key_down;
        n_dec.handled    = (mod_mask != 8'h00) || (hid != 8'h00);
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule
`default_nettype wire

FILE: hdl/khr_key_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khr_key_cell: one key slot of the report
// Holds one HID usage, fills on a press and shifts left on a release.
// ----------------------------------------------------------------------------
module khr_key_cell import khr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_cmd  i_cmd,
    input  wire t_cell_link i_link,
    input  wire logic [7:0] i_right_key,
    output t_cell_link      o_link,
    output logic [7:0]      o_key,
    output logic [7:0]      o_next_key
);

    logic [7:0] r_key;
    logic [7:0] n_key;
    logic       self_hit;
    logic       self_free;

    // match and free flags run along the row
    always_comb begin
        self_hit    = (r_key == i_cmd.hid);
        self_free   = (r_key == 8'h00);
        o_link.hit  = i_link.hit | self_hit;
        o_link.free = i_link.free | self_free;
    end

    // release: this slot and all after the first match take the right value
    // press: first empty slot takes the key unless it is held anywhere
    always_comb begin
        priority if (i_cmd.release_key && o_link.hit) begin
            n_key = i_right_key;
        end else if (i_cmd.press && !i_cmd.any_hit && self_free && !i_link.free) begin
            n_key = i_cmd.hid;
        end else begin
            n_key = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= 8'h00;
        end else begin
            r_key <= n_key;
        end
    end

    assign o_key      = r_key;
    assign o_next_key = n_key;

endmodule
`default_nettype wire

FILE: hdl/key_event_to_hid_report.sv
`default_nettype none
// Path: each key event is registered in the decode stage, then its report in the output register.
// Throughput: one event per cycle while the output is not stalled; the slot update is a single
//   pass along the row of key cells, so each event sees the state left by the one before.
// Reset (synchronous, active low) clears the modifier byte, all key slots and
//   both valid flags.
// ----------------------------------------------------------------------------
// key_event_to_hid_report: HID boot keyboard report builder
// Decodes key events and keeps the modifier byte and six-key slot row.
// ----------------------------------------------------------------------------
module key_event_to_hid_report import khr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_key_event  i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_hid_report      o_out_data
);

    logic        en;
    logic        dec_valid;
    t_decoded    dec;
    logic        apply;
    t_cell_cmd   cmd;
    t_cell_link  link [0:KEY_SLOTS];
    logic [7:0]  key      [0:KEY_SLOTS-1];
    logic [7:0]  next_key [0:KEY_SLOTS-1];
    logic [7:0]  out_slot [0:OUT_SLOTS-1];
    logic [7:0]  r_mod;
    logic [7:0]  n_mod;
    logic        r_out_valid;
    t_hid_report r_out;
    t_hid_report n_out;

    // the pipe moves unless a finished report is held back
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;
    assign apply      = en && dec_valid;

    khr_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_event (i_in_data),
        .o_valid (dec_valid),
        .o_dec   (dec)
    );

    // command for the cell row; hid is zero for modifiers
    always_comb begin
        cmd.hid         = dec.hid;
        cmd.press       = apply && dec.key_down && (dec.hid != 8'h00);
        cmd.release_key = apply && !dec.key_down && (dec.hid != 8'h00);
        cmd.any_hit     = link[KEY_SLOTS].hit;
    end

    assign link[0] = '{hit: 1'b0, free: 1'b0};

    // row of key cells
    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_cell
        logic [7:0] right_key;
        if (g == KEY_SLOTS - 1) begin : g_last
            assign right_key = 8'h00;
        end else begin : g_mid
            assign right_key = key[g+1];
        end

        khr_key_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_link      (link[g]),
            .i_right_key (right_key),
            .o_link      (link[g+1]),
            .o_key       (key[g]),
            .o_next_key  (next_key[g])
        );
    end

    // report slots past the row read as empty
    for (genvar s = 0; s < OUT_SLOTS; s++) begin : g_out
        if (s < KEY_SLOTS) begin : g_used
            assign out_slot[s] = next_key[s];
        end else begin : g_empty
            assign out_slot[s] = 8'h00;
        end
    end

    // modifier byte update
    always_comb begin
        n_mod = r_mod;
        if (apply && (dec.mod_mask != 8'h00)) begin
            n_mod = dec.key_down ? (r_mod | dec.mod_mask) : (r_mod & ~dec.mod_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= 8'h00;
        end else begin
            r_mod <= n_mod;
        end
    end

    // next report
    always_comb begin
        n_out.handled       = dec.handled;
        n_out.modifier_byte = n_mod;
        n_out.slot_zero     = out_slot[0];
        n_out.slot_one      = out_slot[1];
        n_out.slot_two      = out_slot[2];
        n_out.slot_three    = out_slot[3];
        n_out.slot_four     = out_slot[4];
        n_out.slot_five     = out_slot[5];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: test/hid_report_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hid_report_checker: report predictor and comparator
// Watches both channels of the key event to HID report converter. Every key
// event transaction taken is run through a local copy of the modifier byte
// and slot row to give the report it should produce. Every report taken is
// compared field by field with the oldest report still owed.
// ----------------------------------------------------------------------------
module hid_report_checker import khr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire t_key_event  i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire t_hid_report i_out_data,
    output int               o_fail_count,
    output int               o_pending
);

    // platform codes of the modifiers, in modifier byte bit order
    localparam logic [7:0] MOD_CODES [8] = '{CODE_LCTRL, CODE_LSHIFT, CODE_LALT,
                                             CODE_LGUI, CODE_RCTRL, CODE_RSHIFT,
                                             CODE_RALT, CODE_RGUI};

    // platform code to HID usage; codes above 112 are all unmapped
    localparam int USAGE_TOP = 112;
    localparam logic [7:0] USAGE_ROM [0:USAGE_TOP] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h27,
        8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25,
        8'h26, 8'h00, 8'h00, 8'h52, 8'h51, 8'h50, 8'h4F, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h05, 8'h06,
        8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E,
        8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16,
        8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h2C, 8'h00,
        8'h00, 8'h00, 8'h28, 8'h2A, 8'h35, 8'h2D, 8'h2E, 8'h2F,
        8'h30, 8'h31, 8'h33, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h29,
        8'h4C
    };

    logic [7:0]  mod_state;
    logic [7:0]  held_usage [KEY_SLOTS];
    t_hid_report expected_reports [$];
    t_hid_report want;
    int          fail_total = 0;
    int          owed = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = owed;

    // update the local report state with one key event, return the report
    function automatic t_hid_report apply_key_event(input t_key_event ev);
        logic [7:0]  mask;
        logic [7:0]  usage;
        logic [7:0]  row [OUT_SLOTS];
        int          hit;
        int          free_at;
        t_hid_report rep;
        mask = '0;
        for (int b = 0; b < 8; b++)
            if (ev.key_code == MOD_CODES[b])
                mask[b] = 1'b1;
        usage = (ev.key_code <= USAGE_TOP) ? USAGE_ROM[ev.key_code] : 8'h00;
        rep.handled = 1'b0;
        if (mask != '0) begin
            // modifiers win over the usage table
            mod_state   = ev.key_down ? (mod_state | mask) : (mod_state & ~mask);
            rep.handled = 1'b1;
        end else if (usage != 8'h00) begin
            rep.handled = 1'b1;
            hit     = -1;
            free_at = -1;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (hit < 0 && held_usage[i] == usage)
                    hit = i;
                if (free_at < 0 && held_usage[i] == 8'h00)
                    free_at = i;
            end
            if (ev.key_down) begin
                // repeated press or full row: nothing stored
                if (hit < 0 && free_at >= 0)
                    held_usage[free_at] = usage;
            end else if (hit >= 0) begin
                // release packs later slots to the left
                for (int i = hit; i < KEY_SLOTS - 1; i++)
                    held_usage[i] = held_usage[i + 1];
                held_usage[KEY_SLOTS - 1] = 8'h00;
            end
        end
        for (int i = 0; i < OUT_SLOTS; i++)
            row[i] = (i < KEY_SLOTS) ? held_usage[i] : 8'h00;
        rep.modifier_byte = mod_state;
        rep.slot_zero     = row[0];
        rep.slot_one      = row[1];
        rep.slot_two      = row[2];
        rep.slot_three    = row[3];
        rep.slot_four     = row[4];
        rep.slot_five     = row[5];
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            fail_total++;
            $display("%0t checker: %s mismatch, expected %02h actual %02h",
                     $time, name, exp_val, act_val);
        end
    endtask

    // predict on each event taken, compare on each report taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mod_state = '0;
            for (int i = 0; i < KEY_SLOTS; i++)
                held_usage[i] = 8'h00;
            expected_reports.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    fail_total++;
                    $display("%0t checker: report with none owed, expected none actual %h",
                             $time, i_out_data);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("handled", {7'd0, want.handled}, {7'd0, i_out_data.handled});
                    check_field("modifier_byte", want.modifier_byte,
                                i_out_data.modifier_byte);
                    check_field("slot_zero", want.slot_zero, i_out_data.slot_zero);
                    check_field("slot_one", want.slot_one, i_out_data.slot_one);
                    check_field("slot_two", want.slot_two, i_out_data.slot_two);
                    check_field("slot_three", want.slot_three, i_out_data.slot_three);
                    check_field("slot_four", want.slot_four, i_out_data.slot_four);
                    check_field("slot_five", want.slot_five, i_out_data.slot_five);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_reports.push_back(apply_key_event(i_in_data));
        end
        owed = expected_reports.size();
    end

endmodule
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: key event to HID report converter testbench
// Drives directed and random key events through the converter under several
// sender idle and receiver stall mixes; the checker predicts and compares
// each report, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb import khr_pkg::*; ();

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_EVENTS = 238;

    localparam logic [7:0] MOD_CODES [8] = '{CODE_LCTRL, CODE_LSHIFT, CODE_LALT,
                                             CODE_LGUI, CODE_RCTRL, CODE_RSHIFT,
                                             CODE_RALT, CODE_RGUI};

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_key_event  in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_hid_report out_data;
    int          fail_count;
    int          pending;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          cycle_count = 0;
    logic [7:0]  mapped_codes [$];

    key_event_to_hid_report i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    hid_report_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        out_stall = ($urandom_range(99) < stall_pct);
    end

    function automatic t_key_event key_ev(input logic [7:0] code, input logic down);
        t_key_event ev;
        ev.key_code = code;
        ev.key_down = down;
        return ev;
    endfunction

    // mostly keys from a ten-key window so the row fills and releases hit
    function automatic t_key_event random_key_event(input int base);
        t_key_event ev;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 15)
            ev.key_code = MOD_CODES[$urandom_range(7)];
        else if (pick < 27)
            ev.key_code = 8'($urandom_range(255));
        else
            ev.key_code = mapped_codes[base + $urandom_range(9)];
        ev.key_down = ($urandom_range(99) < 55);
        return ev;
    endfunction

    // one transaction, with random idle cycles in front
    task automatic send_event(input t_key_event ev);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid = 1'b0;
            in_data  = t_key_event'($urandom);
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = ev;
        do
            @(posedge i_clk);
        while (in_stall);
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        int base;
        idle_pct  = idle;
        stall_pct = stall;
        base = $urandom_range(mapped_codes.size() - 10);
        repeat (count)
            send_event(random_key_event(base));
        pause_until_drained();
    endtask

    initial begin
        for (int c = 0; c < 256; c++)
            if ((c >= 7 && c <= 16) || (c >= 19 && c <= 22) || (c >= 29 && c <= 54) ||
                c == 61 || c == 62 || (c >= 66 && c <= 75) || c == 111 || c == 112)
                mapped_codes.push_back(8'(c));

        // reset held, then released on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // every modifier pressed, two released
        for (int b = 0; b < 8; b++)
            send_event(key_ev(MOD_CODES[b], 1'b1));
        send_event(key_ev(CODE_LCTRL, 1'b0));
        send_event(key_ev(CODE_RGUI, 1'b0));
        // unmapped codes at both ends of the range
        send_event(key_ev(8'd0, 1'b1));
        send_event(key_ev(8'd255, 1'b1));
        send_event(key_ev(8'd255, 1'b0));
        // fill the row, with a repeated press on the way
        send_event(key_ev(8'd7, 1'b1));
        send_event(key_ev(8'd8, 1'b1));
        send_event(key_ev(8'd29, 1'b1));
        send_event(key_ev(8'd62, 1'b1));
        send_event(key_ev(8'd111, 1'b1));
        send_event(key_ev(8'd111, 1'b1));
        send_event(key_ev(8'd112, 1'b1));
        // row full: press dropped
        send_event(key_ev(8'd22, 1'b1));
        // release of a key not held, then one from the middle
        send_event(key_ev(8'd30, 1'b0));
        send_event(key_ev(8'd8, 1'b0));
        send_event(key_ev(8'd22, 1'b1));
        pause_until_drained();

        run_phase(0, 0, PHASE_EVENTS);
        run_phase(51, 0, PHASE_EVENTS);
        run_phase(0, 51, PHASE_EVENTS);
        run_phase(16, 16, PHASE_EVENTS);

        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
hdl/khr_pkg.sv
hdl/khr_decode.sv
hdl/khr_key_cell.sv
hdl/key_event_to_hid_report.sv
test/hid_report_checker.sv
test/tb.sv
